### rtl/trdt_pkg.sv
// Package for the triangle raster and depth test core.
// Shared constants, state encoding and divider control types.
// No dependencies.
`default_nettype none
package trdt_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int DEPTH_BITS  = 16;
  localparam int STORE_SIZE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_SIZE);
  localparam int COORD_W     = 11;
  localparam int Z_W         = 16;
  localparam int PIX_W       = 8;
  localparam int DIM_W       = 9;
  localparam int WEIGHT_W    = 17;
  localparam int QUO_OPND_W  = 24;
  localparam int DIV_STEPS   = 17;
  localparam int DIV_CNT_W   = 5;

  localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(65536);
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_UV    = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_DEP   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

endpackage
`default_nettype wire

### rtl/trdt_if.sv
// Channel interfaces for the triangle raster core.
// Depends on trdt_pkg for field widths.
`default_nettype none
interface trdt_tri_if;
  import trdt_pkg::*;
  logic valid;
  logic ready;
  logic opcode;
  logic signed [COORD_W-1:0] vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y;
  logic signed [Z_W-1:0] vert0_z, vert1_z, vert2_z;
  modport source (output valid, opcode, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y,
                  vert1_z, vert2_x, vert2_y, vert2_z, input ready);
  modport sink (input valid, opcode, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y,
                vert1_z, vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface trdt_pix_if;
  import trdt_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic written;
  logic [WEIGHT_W-1:0] weight_a, weight_b, weight_c;
  logic signed [Z_W-1:0] depth_out;
  logic last_pixel;
  modport source (output valid, pixel_x, pixel_y, written, weight_a, weight_b, weight_c,
                  depth_out, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, written, weight_a, weight_b, weight_c,
                depth_out, last_pixel, output ready);
endinterface
`default_nettype wire

### rtl/trdt_div.sv
// Radix-2 restoring divider: floor(num * 2^16 / den) for num <= den.
// Depends on trdt_pkg.
`default_nettype none
module trdt_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire trdt_pkg::div_ctl_t            ctl,
  input  wire logic [trdt_pkg::QUO_OPND_W-1:0] num,
  input  wire logic [trdt_pkg::QUO_OPND_W-1:0] den,
  output      trdt_pkg::div_stat_t           stat,
  output      logic [trdt_pkg::WEIGHT_W-1:0] quot
);
  import trdt_pkg::*;

  logic [QUO_OPND_W:0]   rem;
  logic [QUO_OPND_W-1:0] dreg;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;
  logic                  ge;
  logic [QUO_OPND_W:0]   rem_sub;

  assign ge      = rem >= {1'b0, dreg};
  assign rem_sub = ge ? (rem - {1'b0, dreg}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= {1'b0, num};
      dreg <= den;
      quot <= '0;
    end else if (busy) begin
      // remainder stays below den, so the doubled value fits
      rem  <= {rem_sub[QUO_OPND_W-1:0], 1'b0};
      quot <= {quot[WEIGHT_W-2:0], ge};
    end
  end

  assign stat.busy = busy;

endmodule
`default_nettype wire

### rtl/triangle_raster_depth_test_core.sv
// Triangle rasteriser with barycentric weights and a 256x256 depth store.
// Depends on trdt_pkg, trdt_if and trdt_div.
//
// After reset the depth store is swept to minimum depth, one entry a cycle; no
// input transfer is taken during the sweep (register writes are). A load transfer
// latches the vertices, then forms the denominator and clipped box. A step transfer
// runs through the product stage, the edge-function stage and, for a covered pixel
// only, the iterations of the two weight dividers, a state to see them finish and
// the depth product stage; then the final compare and write-back on the depth
// store's single write port. The finished pixel sits in an output register, so the
// next item is taken while it waits; a new result waits only if that register is
// still full.
// A step with no triangle active is taken and gives nothing. Register changes
// take effect at the next load; the store address uses the current width.
`default_nettype none
module triangle_raster_depth_test_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  trdt_tri_if.sink                        tri_chan,
  trdt_pix_if.source                      pix_chan,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [trdt_pkg::DIM_W-1:0] cfg_data
);
  import trdt_pkg::*;

  state_t state, state_next;

  // configuration
  logic [DIM_W-1:0] image_width, image_height;
  logic [DIM_W-1:0] effw, effh;
  logic [PIX_W-1:0] effw_m1, effh_m1;

  // triangle
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [Z_W-1:0]     az, bz, cz;
  logic signed [24:0]        denom;
  logic [PIX_W-1:0]          box_x0, box_x1, box_y0, box_y1;
  logic [PIX_W-1:0]          cur_x, cur_y;
  logic                      active;

  // depth store
  logic signed [DEPTH_BITS-1:0] mem [STORE_SIZE];
  logic [ADDR_W-1:0]            clr_cnt;
  logic [ADDR_W-1:0]            st_addr;
  logic signed [DEPTH_BITS-1:0] rd_q;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic signed [DEPTH_BITS-1:0] mem_wdata;

  // pixel datapath
  logic signed [23:0] p0, p1, p2, p3;
  logic               covered;
  logic signed [33:0] pa, pb, pc;
  logic [WEIGHT_W-1:0] wa, wb, wc;

  // output register
  logic                  ovalid;
  logic [PIX_W-1:0]      o_x, o_y;
  logic                  o_written, o_last;
  logic [WEIGHT_W-1:0]   o_wa, o_wb, o_wc;
  logic signed [Z_W-1:0] o_depth;

  logic in_xfer, out_free, fin_go;

  assign tri_chan.ready = (state == ST_IDLE);
  assign in_xfer        = tri_chan.valid && tri_chan.ready;
  assign out_free       = !ovalid || pix_chan.ready;
  assign fin_go         = (state == ST_FIN) && out_free;

  // effective image size: zero acts as one, large values saturate
  always_comb begin
    if (image_width == '0) effw = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH)) effw = DIM_W'(MAX_WIDTH);
    else effw = image_width;
    if (image_height == '0) effh = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) effh = DIM_W'(MAX_HEIGHT);
    else effh = image_height;
    effw_m1 = PIX_W'(effw - 1'b1);
    effh_m1 = PIX_W'(effh - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(256);
      image_height <= DIM_W'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  // ---------------- load: denominator and clipped box ----------------
  logic signed [11:0] l_dcy, l_dbx, l_dby, l_dcx;
  logic signed [23:0] l_m0, l_m1;
  logic signed [24:0] denom_c;
  logic signed [COORD_W-1:0] minx, maxx, miny, maxy, lox, hix, loy, hiy;
  logic box_ok;

  always_comb begin
    l_dcy   = {cy[COORD_W-1], cy} - {ay[COORD_W-1], ay};
    l_dbx   = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    l_dby   = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    l_dcx   = {cx[COORD_W-1], cx} - {ax[COORD_W-1], ax};
    l_m0    = l_dcy * l_dbx;
    l_m1    = l_dby * l_dcx;
    denom_c = {l_m0[23], l_m0} - {l_m1[23], l_m1};

    minx = (ax < bx) ? ax : bx;  minx = (minx < cx) ? minx : cx;
    maxx = (ax > bx) ? ax : bx;  maxx = (maxx > cx) ? maxx : cx;
    miny = (ay < by) ? ay : by;  miny = (miny < cy) ? miny : cy;
    maxy = (ay > by) ? ay : by;  maxy = (maxy > cy) ? maxy : cy;
    lox  = minx[COORD_W-1] ? '0 : minx;
    loy  = miny[COORD_W-1] ? '0 : miny;
    hix  = (maxx > $signed({3'b000, effw_m1})) ? $signed({3'b000, effw_m1}) : maxx;
    hiy  = (maxy > $signed({3'b000, effh_m1})) ? $signed({3'b000, effh_m1}) : maxy;
    box_ok = (lox <= hix) && (loy <= hiy);
  end

  // ---------------- pixel edge functions ----------------
  logic signed [11:0] dxa, dya, e_dby, e_dbx, e_dcx, e_dcy;
  logic [16:0]        addr_w;
  logic [ADDR_W-1:0]  addr_c;

  always_comb begin
    dxa   = {ax[COORD_W-1], ax} - $signed({4'b0000, cur_x});
    dya   = {ay[COORD_W-1], ay} - $signed({4'b0000, cur_y});
    e_dby = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    e_dbx = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    e_dcx = {cx[COORD_W-1], cx} - {ax[COORD_W-1], ax};
    e_dcy = {cy[COORD_W-1], cy} - {ay[COORD_W-1], ay};
    addr_w = {9'b0, cur_x} + (17'(cur_y) * 17'(effw));
    addr_c = (addr_w > 17'(STORE_SIZE - 1)) ? ADDR_W'(STORE_SIZE - 1) : addr_w[ADDR_W-1:0];
  end

  // sign-normalised U, V, D and the exact coverage test
  logic signed [24:0] u_c, v_c, un, vn;
  logic [23:0]        dabs;
  logic [25:0]        uv_sum;
  logic               cov_c;

  always_comb begin
    u_c    = {p0[23], p0} - {p1[23], p1};
    v_c    = {p2[23], p2} - {p3[23], p3};
    un     = denom[24] ? -u_c : u_c;
    vn     = denom[24] ? -v_c : v_c;
    dabs   = denom[24] ? 24'(-denom) : denom[23:0];
    uv_sum = {un[24], un} + {vn[24], vn};
    cov_c  = !un[24] && !vn[24] && ($signed(uv_sum) <= $signed({2'b00, dabs}));
  end

  // ---------------- weight dividers ----------------
  div_ctl_t  div_ctl;
  div_stat_t stat_v, stat_u;
  logic [WEIGHT_W-1:0] q_v, q_u;

  assign div_ctl.start = (state == ST_UV) && cov_c;

  trdt_div u_div_v (
    .clk, .rst, .ctl(div_ctl), .num(vn[23:0]), .den(dabs), .stat(stat_v), .quot(q_v)
  );
  trdt_div u_div_u (
    .clk, .rst, .ctl(div_ctl), .num(un[23:0]), .den(dabs), .stat(stat_u), .quot(q_u)
  );

  // ---------------- depth sum and test ----------------
  logic [WEIGHT_W:0]     wa_full;
  logic signed [35:0]    sum, thr;
  logic                  pass;
  logic signed [Z_W-1:0] depth_c;

  always_comb begin
    wa_full = {1'b0, W_ONE} - {1'b0, q_v} - {1'b0, q_u};
    sum     = {{2{pa[33]}}, pa} + {{2{pb[33]}}, pb} + {{2{pc[33]}}, pc};
    thr     = {{4{rd_q[DEPTH_BITS-1]}}, rd_q, 16'b0};
    pass    = covered && (sum > thr);
    // truncate toward zero
    depth_c = sum[31:16] + ((sum[35] && (sum[15:0] != '0)) ? 16'sd1 : 16'sd0);
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == ADDR_W'(STORE_SIZE - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          if (tri_chan.opcode == OP_LOAD) state_next = ST_LOAD;
          else if (active) state_next = ST_MUL;
        end
      end
      ST_LOAD: state_next = ST_IDLE;
      ST_MUL:  state_next = ST_UV;
      ST_UV:   state_next = cov_c ? ST_DIV : ST_FIN;
      ST_DIV:  if (!stat_v.busy && !stat_u.busy) state_next = ST_DEP;
      ST_DEP:  state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      active  <= 1'b0;
      cur_x   <= '0;
      cur_y   <= '0;
      box_x0  <= '0;
      box_x1  <= '0;
      box_y0  <= '0;
      box_y1  <= '0;
      ovalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_LOAD) begin
        box_x0 <= lox[PIX_W-1:0];
        box_x1 <= hix[PIX_W-1:0];
        box_y0 <= loy[PIX_W-1:0];
        box_y1 <= hiy[PIX_W-1:0];
        cur_x  <= lox[PIX_W-1:0];
        cur_y  <= loy[PIX_W-1:0];
        active <= (denom_c != '0) && box_ok;
      end
      if (fin_go) begin
        ovalid <= 1'b1;
        if (cur_x == box_x1 && cur_y == box_y1) begin
          active <= 1'b0;
        end else if (cur_y < box_y1) begin
          cur_y <= cur_y + 1'b1;
        end else begin
          cur_y <= box_y0;
          cur_x <= cur_x + 1'b1;
        end
      end else if (pix_chan.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer && tri_chan.opcode == OP_LOAD) begin
      ax <= tri_chan.vert0_x;  ay <= tri_chan.vert0_y;  az <= tri_chan.vert0_z;
      bx <= tri_chan.vert1_x;  by <= tri_chan.vert1_y;  bz <= tri_chan.vert1_z;
      cx <= tri_chan.vert2_x;  cy <= tri_chan.vert2_y;  cz <= tri_chan.vert2_z;
    end
    if (state == ST_LOAD) denom <= denom_c;
    if (state == ST_MUL) begin
      p0      <= e_dby * dxa;
      p1      <= dya * e_dbx;
      p2      <= dya * e_dcx;
      p3      <= e_dcy * dxa;
      st_addr <= addr_c;
    end
    if (state == ST_UV) covered <= cov_c;
    if (state == ST_DEP) begin
      wa <= wa_full[WEIGHT_W-1:0];
      wb <= q_v;
      wc <= q_u;
      pa <= $signed({{18{az[Z_W-1]}}, az}) * $signed({17'b0, wa_full[WEIGHT_W-1:0]});
      pb <= $signed({{18{bz[Z_W-1]}}, bz}) * $signed({17'b0, q_v});
      pc <= $signed({{18{cz[Z_W-1]}}, cz}) * $signed({17'b0, q_u});
    end
    if (fin_go) begin
      o_x       <= cur_x;
      o_y       <= cur_y;
      o_written <= pass;
      o_wa      <= pass ? wa : '0;
      o_wb      <= pass ? wb : '0;
      o_wc      <= pass ? wc : '0;
      o_depth   <= pass ? depth_c : '0;
      o_last    <= (cur_x == box_x1) && (cur_y == box_y1);
    end
  end

  // depth store: one write port shared by the clearing sweep and the write-back
  always_comb begin
    mem_we    = (state == ST_CLEAR) || (fin_go && pass);
    mem_waddr = (state == ST_CLEAR) ? clr_cnt : st_addr;
    mem_wdata = (state == ST_CLEAR) ? DEPTH_MIN : depth_c;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) rd_q <= mem[addr_c];
  end

  assign pix_chan.valid      = ovalid;
  assign pix_chan.pixel_x    = o_x;
  assign pix_chan.pixel_y    = o_y;
  assign pix_chan.written    = o_written;
  assign pix_chan.weight_a   = o_wa;
  assign pix_chan.weight_b   = o_wb;
  assign pix_chan.weight_c   = o_wc;
  assign pix_chan.depth_out  = o_depth;
  assign pix_chan.last_pixel = o_last;

endmodule
`default_nettype wire

### rtl/trdt_checker.sv
// Port-level checks for triangle_raster_depth_test_core, with its bind.
// Depends on trdt_pkg.
`default_nettype none
module trdt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            written,
  input wire logic [trdt_pkg::PIX_W-1:0]      pixel_x,
  input wire logic [trdt_pkg::WEIGHT_W-1:0]   weight_a,
  input wire logic [trdt_pkg::WEIGHT_W-1:0]   weight_b,
  input wire logic [trdt_pkg::WEIGHT_W-1:0]   weight_c,
  input wire logic signed [trdt_pkg::Z_W-1:0] depth_out
);
  import trdt_pkg::*;

  // store sweep follows reset, so no input transfer right after it
  a_clear_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !in_ready)
    else $error("input ready right after reset");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !written |-> weight_a == '0 && weight_b == '0 && weight_c == '0 &&
                              depth_out == '0)
    else $error("unwritten pixel carries weights or depth");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && written |->
      ({2'b00, weight_a} + {2'b00, weight_b} + {2'b00, weight_c}) == 19'(W_ONE))
    else $error("weights do not sum to one");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x))
    else $error("stalled result changed");

endmodule

bind triangle_raster_depth_test_core trdt_checker u_trdt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (tri_chan.ready),
  .out_valid (pix_chan.valid),
  .out_ready (pix_chan.ready),
  .written   (pix_chan.written),
  .pixel_x   (pix_chan.pixel_x),
  .weight_a  (pix_chan.weight_a),
  .weight_b  (pix_chan.weight_b),
  .weight_c  (pix_chan.weight_c),
  .depth_out (pix_chan.depth_out)
);
`default_nettype wire

### tb/triangle_raster_depth_test_core_test.sv
// Testbench for triangle_raster_depth_test_core: triangle loads and pixel steps
// are checked against a behavioural rasteriser with its own depth store.
// Depends on trdt_pkg and the trdt_tri_if / trdt_pix_if interfaces.
`timescale 1ns / 100ps

module triangle_raster_depth_test_core_test;
  import trdt_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 40;   // outlasts a covered step in the block

  typedef struct {
    logic                      opcode;
    logic signed [COORD_W-1:0] vx[3];
    logic signed [COORD_W-1:0] vy[3];
    logic signed [Z_W-1:0]     vz[3];
  } tri_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic                written;
    logic [WEIGHT_W-1:0] weight_a;
    logic [WEIGHT_W-1:0] weight_b;
    logic [WEIGHT_W-1:0] weight_c;
    logic signed [Z_W-1:0] depth_out;
    logic                last_pixel;
  } pixel_res_t;

  // Rasteriser model plus the queue of pixels still owed by the block.
  class raster_scoreboard;
    shortint      zbuf[STORE_SIZE];
    longint       vx[3], vy[3], vz[3];
    longint       denom, cur_x, cur_y, bx0, bx1, by0, by1;
    bit           walking;
    bit [DIM_W-1:0] width_reg, height_reg;
    pixel_res_t   pending_pixels[$];
    int           mismatches;

    function new();
      foreach (zbuf[i]) zbuf[i] = DEPTH_MIN;
      foreach (vx[k]) begin
        vx[k] = 0; vy[k] = 0; vz[k] = 0;
      end
      denom = 0; cur_x = 0; cur_y = 0;
      bx0 = 0; bx1 = 0; by0 = 0; by1 = 0;
      walking = 0;
      width_reg = 256; height_reg = 256;
      mismatches = 0;
    endfunction

    function longint eff_w();
      if (width_reg == 0) return 1;
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function longint eff_h();
      if (height_reg == 0) return 1;
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    // Steps still needed to finish the current walk.
    function longint walk_left();
      if (!walking) return 0;
      return (bx1 - cur_x) * (by1 - by0 + 1) + (by1 - cur_y) + 1;
    endfunction

    function void set_reg(logic idx, bit [DIM_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // Accepted input transfer: update the model, queue any pixel it yields.
    function void note(tri_item_t t);
      longint u, v, d, w0, w1, w2, sum, dep, st;
      int unsigned idx;
      pixel_res_t r;
      if (t.opcode == OP_LOAD) begin
        foreach (vx[k]) begin
          vx[k] = t.vx[k]; vy[k] = t.vy[k]; vz[k] = t.vz[k];
        end
        denom = (vy[2] - vy[0]) * (vx[1] - vx[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
        bx0 = vx[0]; bx1 = vx[0]; by0 = vy[0]; by1 = vy[0];
        for (int k = 1; k < 3; k++) begin
          if (vx[k] < bx0) bx0 = vx[k];
          if (vx[k] > bx1) bx1 = vx[k];
          if (vy[k] < by0) by0 = vy[k];
          if (vy[k] > by1) by1 = vy[k];
        end
        if (bx0 < 0) bx0 = 0;
        if (by0 < 0) by0 = 0;
        if (bx1 > eff_w() - 1) bx1 = eff_w() - 1;
        if (by1 > eff_h() - 1) by1 = eff_h() - 1;
        cur_x = bx0; cur_y = by0;
        walking = (denom != 0) && (bx0 <= bx1) && (by0 <= by1);
        return;
      end
      if (!walking) return;  // step with no triangle: ignored
      u = (vy[1] - vy[0]) * (vx[0] - cur_x) - (vy[0] - cur_y) * (vx[1] - vx[0]);
      v = (vy[0] - cur_y) * (vx[2] - vx[0]) - (vy[2] - vy[0]) * (vx[0] - cur_x);
      d = denom;
      if (d < 0) begin
        d = -d; u = -u; v = -v;
      end
      r = '0;
      r.pixel_x = cur_x[PIX_W-1:0];
      r.pixel_y = cur_y[PIX_W-1:0];
      if (u >= 0 && v >= 0 && u + v <= d) begin
        w1 = (v * 65536) / d;
        w2 = (u * 65536) / d;
        w0 = 65536 - w1 - w2;
        idx = cur_x + cur_y * eff_w();
        if (idx >= STORE_SIZE) idx = STORE_SIZE - 1;
        sum = vz[0] * w0 + vz[1] * w1 + vz[2] * w2;
        if (sum > longint'(zbuf[idx]) * 65536) begin
          dep = sum / 65536;   // truncates toward zero
          st = dep;
          if (st < -32768) st = -32768;
          if (st > 32767) st = 32767;
          zbuf[idx] = st;
          r.written = 1'b1;
          r.weight_a = w0; r.weight_b = w1; r.weight_c = w2;
          r.depth_out = dep[Z_W-1:0];
        end
      end
      r.last_pixel = (cur_x == bx1) && (cur_y == by1);
      if (r.last_pixel) walking = 0;
      else if (cur_y < by1) cur_y++;
      else begin
        cur_y = by0; cur_x++;
      end
      pending_pixels.push_back(r);
    endfunction

    function void check(pixel_res_t got);
      pixel_res_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel transfer: %p", got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_index;
  logic [DIM_W-1:0] cfg_data;
  int unsigned cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  trdt_tri_if tri_c ();
  trdt_pix_if pix_c ();

  raster_scoreboard sb = new();

  triangle_raster_depth_test_core u_top (
    .clk      (clk),
    .rst      (rst),
    .tri_chan (tri_c),
    .pix_chan (pix_c),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: the run never takes this long when the block behaves.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random back-pressure at the phase's stall rate.
  always @(posedge clk) begin
    pix_c.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Pixel monitor: ready is our own register, so its pre-edge value is the one seen here.
  always @(posedge clk) begin
    pixel_res_t got;
    if (!rst && pix_c.valid && pix_c.ready) begin
      got.pixel_x = pix_c.pixel_x;
      got.pixel_y = pix_c.pixel_y;
      got.written = pix_c.written;
      got.weight_a = pix_c.weight_a;
      got.weight_b = pix_c.weight_b;
      got.weight_c = pix_c.weight_c;
      got.depth_out = pix_c.depth_out;
      got.last_pixel = pix_c.last_pixel;
      sb.check(got);
    end
  end

  // One input transfer, with optional idle gaps in front; valid stays high after it
  // so back-to-back transfers never see valid dropped and raised in one step.
  task automatic send(tri_item_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      tri_c.valid <= 1'b0;
      @(posedge clk);
    end
    tri_c.valid <= 1'b1;
    tri_c.opcode <= t.opcode;
    tri_c.vert0_x <= t.vx[0]; tri_c.vert0_y <= t.vy[0]; tri_c.vert0_z <= t.vz[0];
    tri_c.vert1_x <= t.vx[1]; tri_c.vert1_y <= t.vy[1]; tri_c.vert1_z <= t.vz[1];
    tri_c.vert2_x <= t.vx[2]; tri_c.vert2_y <= t.vy[2]; tri_c.vert2_z <= t.vz[2];
    do @(posedge clk); while (!tri_c.ready);
    sb.note(t);
  endtask

  // Vertex fields fully random; step items carry junk there too.
  function automatic tri_item_t rand_item(logic op);
    tri_item_t t;
    t.opcode = op;
    foreach (t.vx[k]) begin
      t.vx[k] = $urandom_range(2047);
      t.vy[k] = $urandom_range(2047);
      t.vz[k] = $urandom_range(65535);
    end
    return t;
  endfunction

  function automatic tri_item_t make_load(int x0, int y0, int x1, int y1, int x2, int y2,
                                          int z0, int z1, int z2);
    tri_item_t t;
    t.opcode = OP_LOAD;
    t.vx[0] = x0; t.vy[0] = y0; t.vz[0] = z0;
    t.vx[1] = x1; t.vy[1] = y1; t.vz[1] = z1;
    t.vx[2] = x2; t.vy[2] = y2; t.vz[2] = z2;
    return t;
  endfunction

  // Small triangle near the visible image; size varies, z is wide-ranging.
  function automatic tri_item_t small_tri();
    tri_item_t t;
    int span, cx, cy;
    span = ($urandom_range(9) == 0) ? 14 : 6;
    cx = int'($urandom_range(sb.eff_w() + 7)) - 4;
    cy = int'($urandom_range(sb.eff_h() + 7)) - 4;
    t = rand_item(OP_LOAD);
    foreach (t.vx[k]) begin
      t.vx[k] = cx + int'($urandom_range(span)) - span / 2;
      t.vy[k] = cy + int'($urandom_range(span)) - span / 2;
      if ($urandom_range(3) == 0) t.vz[k] = int'($urandom_range(400)) - 200;
    end
    return t;
  endfunction

  task automatic step_n(longint n);
    repeat (n) send(rand_item(OP_STEP));
  endtask

  // Block idle: valid dropped, all pixels in, then room for any load still in flight.
  task automatic drain();
    tri_c.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic directed();
    step_n(2);                                                    // step while idle
    send(make_load(0, 0, 4, 0, 0, 4, 100, 200, 300));             // basic right triangle
    step_n(sb.walk_left());
    send(make_load(0, 0, 4, 0, 0, 4, 50, 50, 50));                // same pixels, fails depth
    step_n(sb.walk_left());
    send(make_load(4, 0, 0, 0, 0, 4, 32767, 32767, 32767));       // negative denominator
    step_n(sb.walk_left());
    send(make_load(0, 3, 5, 3, 9, 3, 1, 2, 3));                   // all y equal
    step_n(2);
    send(make_load(0, 0, 2, 2, 4, 4, 1, 2, 3));                   // collinear
    step_n(1);
    send(make_load(-9, -9, -3, -9, -9, -2, 5, 5, 5));             // clipped box empty
    step_n(1);
    send(make_load(-1024, -1024, 1023, -1024, -1024, 1023, -32768, 32767, 0));
    step_n(3);                                                    // huge, then replaced
    send(make_load(1023, 1023, -1024, 1023, 1023, -1024, 32767, -32768, -1));
    step_n(3);
    send(make_load(250, 250, 262, 252, 251, 262, -32768, -32768, -32768));
    step_n(sb.walk_left());                                       // right/bottom clip
  endtask

  initial begin
    int items;
    int phase_items;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    tri_c.valid = 1'b0;
    tri_c.opcode = OP_LOAD;
    {tri_c.vert0_x, tri_c.vert0_y, tri_c.vert0_z} = '0;
    {tri_c.vert1_x, tri_c.vert1_y, tri_c.vert1_z} = '0;
    {tri_c.vert2_x, tri_c.vert2_y, tri_c.vert2_z} = '0;
    pix_c.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed();
    drain();  // sender holds off until every pixel is back

    items = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 25; snk_stall_pct = 25; end
      endcase
      // Register settings per phase, extremes included.
      case (ph)
        0: begin write_reg(REG_IMAGE_WIDTH, 9'd256); write_reg(REG_IMAGE_HEIGHT, 9'd256); end
        1: begin write_reg(REG_IMAGE_WIDTH, 9'd0);   write_reg(REG_IMAGE_HEIGHT, 9'd511); end
        2: begin write_reg(REG_IMAGE_WIDTH, 9'd17);  write_reg(REG_IMAGE_HEIGHT, 9'd9);   end
        3: begin write_reg(REG_IMAGE_WIDTH, 9'd511); write_reg(REG_IMAGE_HEIGHT, 9'd0);   end
        4: begin write_reg(REG_IMAGE_WIDTH, 9'd1);   write_reg(REG_IMAGE_HEIGHT, 9'd1);   end
        default: begin
          write_reg(REG_IMAGE_WIDTH, 9'd100); write_reg(REG_IMAGE_HEIGHT, 9'd200);
        end
      endcase
      phase_items = 0;
      while (phase_items < 220) begin
        case ($urandom_range(9))
          0: begin  // noise: full-range load, a few steps, then replaced
            send(rand_item(OP_LOAD));
            step_n($urandom_range(3));
            phase_items += 1;
          end
          1: begin  // broken walk: stop partway
            send(small_tri());
            step_n(sb.walk_left() / 2);
            phase_items += 1 + int'(sb.walk_left());
          end
          default: begin  // well-formed walk to the last pixel
            send(small_tri());
            phase_items += 1 + int'(sb.walk_left());
            step_n(sb.walk_left());
          end
        endcase
      end
      items += phase_items;
      drain();
    end

    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### triangle_raster_depth_test_core.f
rtl/trdt_pkg.sv
rtl/trdt_if.sv
rtl/trdt_div.sv
rtl/triangle_raster_depth_test_core.sv
rtl/trdt_checker.sv
tb/triangle_raster_depth_test_core_test.sv
